FILE: hw/rtl/lhpf_pkg.sv
// Shared types and constants for the lane histogram peak finder.
// Used by the front, back and top modules; depends on nothing.
`default_nettype none

package lhpf_pkg;

   // Field widths
   localparam int PIX_W    = 1;
   localparam int COL_W    = 9;
   localparam int ROW_W    = 8;
   localparam int FWID_W   = 10;
   localparam int RHGT_W   = 9;
   localparam int LEND_W   = 10;
   localparam int CERR_W   = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // Wide scratch width for compares against the size parameters (up to 8191)
   localparam int WIDE_W = 13;

   // Saturation limit of a column count
   localparam logic [COL_W-1:0] COUNT_MAX = 9'd511;

   // Queue sizes
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Register reset values
   localparam logic [FWID_W-1:0] FRAME_WIDTH_RESET = 10'd360;
   localparam logic [ROW_W-1:0]  ROI_TOP_RESET     = 8'd140;
   localparam logic [RHGT_W-1:0] ROI_HEIGHT_RESET  = 9'd100;
   localparam logic [LEND_W-1:0] LEFT_END_RESET    = 10'd135;
   localparam logic [COL_W-1:0]  RIGHT_START_RESET = 9'd225;
   localparam logic [COL_W-1:0]  CENTER_REF_RESET  = 9'd183;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH = 3'd0,
      CSR_ROI_TOP     = 3'd1,
      CSR_ROI_HEIGHT  = 3'd2,
      CSR_LEFT_END    = 3'd3,
      CSR_RIGHT_START = 3'd4,
      CSR_CENTER_REF  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [FWID_W-1:0] frame_width;
      logic [ROW_W-1:0]  roi_top;
      logic [RHGT_W-1:0] roi_height;
      logic [LEND_W-1:0] left_end;
      logic [COL_W-1:0]  right_start;
      logic [COL_W-1:0]  center_ref;
   } cfg_type;

   // Classified in-band pixel, front to back
   typedef struct packed {
      logic             pix;
      logic [COL_W-1:0] col;
      logic             first_row;
      logic             last_row;
      logic             last_pix;
      logic             in_left;
      logic             in_right;
   } cmd_type;

   typedef struct packed {
      logic [COL_W-1:0]  left_position;
      logic [COL_W-1:0]  right_position;
      logic [COL_W-1:0]  lane_center;
      logic [CERR_W-1:0] center_error;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/lhpf_queue.sv
// Small register FIFO used for the command and response queues.
// Generic over payload width and depth; no package dependency.
`default_nettype none

module lhpf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/lhpf_front.sv
// Front end: accepts pixel requests, drops those outside the band or frame
// and tags the rest for the back end. Depends on lhpf_pkg.
`default_nettype none

module lhpf_front #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                            req_push,
   input  logic                            cmd_full,
   input  logic [lhpf_pkg::PIX_W-1:0]      req_pixel_on,
   input  logic [lhpf_pkg::COL_W-1:0]      req_column,
   input  logic [lhpf_pkg::ROW_W-1:0]      req_row,
   input  lhpf_pkg::cfg_type               cfg,
   output logic                            cmd_push,
   output lhpf_pkg::cmd_type               cmd
);

   localparam int W = lhpf_pkg::WIDE_W;
   localparam logic [W-1:0] MaxW = W'(MAX_WIDTH);
   localparam logic [W-1:0] MaxH = W'(MAX_HEIGHT);

   logic [W-1:0]                   width_eff, height_eff;
   logic [W-1:0]                   col_wide, off_wide;
   logic [lhpf_pkg::ROW_W-1:0]     off;
   logic                           in_frame, in_band, last_row;

   always_comb begin
      width_eff  = ({3'b0, cfg.frame_width} > MaxW) ? MaxW : {3'b0, cfg.frame_width};
      height_eff = ({4'b0, cfg.roi_height} > MaxH) ? MaxH : {4'b0, cfg.roi_height};
      col_wide   = {4'b0, req_column};
      off        = req_row - cfg.roi_top;
      off_wide   = {5'b0, off};
      // col < width also keeps the column inside the count memory
      in_frame   = (col_wide < width_eff);
      in_band    = (req_row >= cfg.roi_top) && (off_wide < height_eff);
      last_row   = (off_wide == height_eff - 1'b1);

      cmd.pix       = req_pixel_on[0];
      cmd.col       = req_column;
      cmd.first_row = (off == '0);
      cmd.last_row  = last_row;
      cmd.last_pix  = last_row && (col_wide == width_eff - 1'b1);
      cmd.in_left   = ({1'b0, req_column} < cfg.left_end);
      cmd.in_right  = (req_column >= cfg.right_start);
   end

   assign cmd_push = req_push && !cmd_full && in_frame && in_band;

endmodule

`default_nettype wire

FILE: hw/rtl/lhpf_back.sv
// Back end: column count read-modify-write, running peak search for both
// ranges and the lane center result. Depends on lhpf_pkg.
`default_nettype none

module lhpf_back #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lhpf_pkg::cfg_type                 cfg,
   input  logic                              cmd_empty,
   input  lhpf_pkg::cmd_type                 cmd_data,
   output logic                              cmd_pop,
   input  logic [lhpf_pkg::RSP_CNT_W-1:0]    rsp_count,
   output logic                              rsp_push,
   output lhpf_pkg::rsp_type                 rsp_data
);

   localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW   = lhpf_pkg::COL_W;
   localparam int EW   = lhpf_pkg::CERR_W;
   localparam int OccW = lhpf_pkg::RSP_CNT_W + 1;

   logic [CW-1:0] count_mem [MAX_WIDTH];

   // Stage 1: item whose count was just read
   logic              s1_valid_ff;
   lhpf_pkg::cmd_type s1_cmd_ff;
   logic [CW-1:0]     rd_data_ff;
   logic              fwd_hit_ff;
   logic [CW-1:0]     fwd_cnt_ff;

   // Running search
   logic [CW-1:0] lbest_cnt_ff, lbest_cnt_in;
   logic [CW-1:0] lbest_col_ff, lbest_col_in;
   logic [CW-1:0] rbest_cnt_ff, rbest_cnt_in;
   logic [CW-1:0] rbest_col_ff, rbest_col_in;
   logic          rseen_ff, rseen_in;

   // Stage 2: result formation
   logic          s2_valid_ff;
   logic [CW-1:0] s2_left_ff, s2_right_ff;
   logic          s2_seen_ff;

   logic [lhpf_pkg::WIDE_W-1:0] head_col_wide, s1_col_wide;
   logic [AW-1:0]  head_addr, s1_addr;
   logic [CW-1:0]  rd_count, s1_cnt;
   logic           left_upd, right_upd, s1_emit;
   logic [OccW-1:0] rsp_occ;
   logic [CW-1:0]  right_pos, center;
   logic [EW-1:0]  diff, diff_adj, half, err;

   assign head_col_wide = {4'b0, cmd_data.col};
   assign s1_col_wide   = {4'b0, s1_cmd_ff.col};
   assign head_addr     = head_col_wide[AW-1:0];
   assign s1_addr       = s1_col_wide[AW-1:0];

   // Pop only when the response queue is sure to have room for every
   // result still in flight, so stages 1 and 2 never stall.
   assign s1_emit = s1_valid_ff && s1_cmd_ff.last_pix;
   assign rsp_occ = {1'b0, rsp_count} + OccW'(s1_emit) + OccW'(s2_valid_ff);
   assign cmd_pop = !cmd_empty && (rsp_occ < OccW'(lhpf_pkg::RSP_DEPTH));

   // Count update; the previous item's write is not yet visible in the read
   always_comb begin
      rd_count = fwd_hit_ff ? fwd_cnt_ff : rd_data_ff;
      if (s1_cmd_ff.first_row) begin
         s1_cnt = {{(CW-1){1'b0}}, s1_cmd_ff.pix};
      end else if (rd_count == lhpf_pkg::COUNT_MAX) begin
         s1_cnt = lhpf_pkg::COUNT_MAX;
      end else begin
         s1_cnt = rd_count + {{(CW-1){1'b0}}, s1_cmd_ff.pix};
      end
   end

   // Peak search, ties keep the lower column
   always_comb begin
      left_upd  = s1_valid_ff && s1_cmd_ff.last_row && s1_cmd_ff.in_left &&
                  ((s1_cnt > lbest_cnt_ff) ||
                   ((s1_cnt == lbest_cnt_ff) && (s1_cmd_ff.col < lbest_col_ff)));
      right_upd = s1_valid_ff && s1_cmd_ff.last_row && s1_cmd_ff.in_right &&
                  (!rseen_ff || (s1_cnt > rbest_cnt_ff) ||
                   ((s1_cnt == rbest_cnt_ff) && (s1_cmd_ff.col < rbest_col_ff)));
      lbest_cnt_in = left_upd ? s1_cnt : lbest_cnt_ff;
      lbest_col_in = left_upd ? s1_cmd_ff.col : lbest_col_ff;
      rbest_cnt_in = right_upd ? s1_cnt : rbest_cnt_ff;
      rbest_col_in = right_upd ? s1_cmd_ff.col : rbest_col_ff;
      rseen_in     = rseen_ff || right_upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         lbest_cnt_ff <= '0;
         lbest_col_ff <= '0;
         rbest_cnt_ff <= '0;
         rbest_col_ff <= '0;
         rseen_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= cmd_pop;
         s2_valid_ff <= s1_emit;
         if (s1_emit) begin
            lbest_cnt_ff <= '0;
            lbest_col_ff <= '0;
            rbest_cnt_ff <= '0;
            rbest_col_ff <= '0;
            rseen_ff     <= 1'b0;
         end else begin
            lbest_cnt_ff <= lbest_cnt_in;
            lbest_col_ff <= lbest_col_in;
            rbest_cnt_ff <= rbest_cnt_in;
            rbest_col_ff <= rbest_col_in;
            rseen_ff     <= rseen_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         s1_cmd_ff <= cmd_data;
      end
      fwd_hit_ff  <= s1_valid_ff && (s1_cmd_ff.col == cmd_data.col);
      fwd_cnt_ff  <= s1_cnt;
      s2_left_ff  <= lbest_col_in;
      s2_right_ff <= rbest_col_in;
      s2_seen_ff  <= rseen_in;
   end

   // Count memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         count_mem[s1_addr] <= s1_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rd_data_ff <= count_mem[head_addr];
      end
   end

   // Midpoint, truncated toward zero, and error against the reference
   always_comb begin
      right_pos = s2_seen_ff ? s2_right_ff : cfg.right_start;
      diff      = {1'b0, right_pos} - {1'b0, s2_left_ff};
      diff_adj  = diff + {{(EW-1){1'b0}}, diff[EW-1]};
      half      = {diff_adj[EW-1], diff_adj[EW-1:1]};
      center    = s2_left_ff + half[CW-1:0];
      err       = {1'b0, center} - {1'b0, cfg.center_ref};

      rsp_data.left_position  = s2_left_ff;
      rsp_data.right_position = right_pos;
      rsp_data.lane_center    = center;
      rsp_data.center_error   = err;
   end

   assign rsp_push = s2_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/lane_histogram_peak_finder.sv
// Lane histogram peak finder: one pixel request per cycle while req_full is low.
// The result of a band's last pixel passes the command queue, count read, search
// and result stages in turn after that request is accepted, then reaches rsp_ ports.
// Throughput is set by the single read-modify-write port of the count memory.
// Reset (synchronous): registers to defaults, search cleared, queues empty;
// the count memory is not cleared, the band's first row initializes it.
`default_nettype none

module lane_histogram_peak_finder #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                                clock,
   input  logic                                reset,

   // Pixel requests
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [lhpf_pkg::PIX_W-1:0]          req_pixel_on,
   input  logic [lhpf_pkg::COL_W-1:0]          req_column,
   input  logic [lhpf_pkg::ROW_W-1:0]          req_row,

   // Results
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [lhpf_pkg::COL_W-1:0]          rsp_left_position,
   output logic [lhpf_pkg::COL_W-1:0]          rsp_right_position,
   output logic [lhpf_pkg::COL_W-1:0]          rsp_lane_center,
   output logic signed [lhpf_pkg::CERR_W-1:0]  rsp_center_error,

   // Register writes
   input  logic                                csr_write_enable,
   input  logic [lhpf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lhpf_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int CmdW = $bits(lhpf_pkg::cmd_type);
   localparam int RspW = $bits(lhpf_pkg::rsp_type);

   lhpf_pkg::cfg_type cfg_ff;

   // Front to back
   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
   lhpf_pkg::cmd_type cmd_in_data, cmd_out_data;

   // Back to response queue
   logic              rsp_push, rsp_full;
   lhpf_pkg::rsp_type rsp_in_data, rsp_out_data;
   logic [lhpf_pkg::RSP_CNT_W-1:0] rsp_count;

   // ---------------------------------------------------------------------
   // Configuration registers. Unlisted indexes are ignored.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width <= lhpf_pkg::FRAME_WIDTH_RESET;
         cfg_ff.roi_top     <= lhpf_pkg::ROI_TOP_RESET;
         cfg_ff.roi_height  <= lhpf_pkg::ROI_HEIGHT_RESET;
         cfg_ff.left_end    <= lhpf_pkg::LEFT_END_RESET;
         cfg_ff.right_start <= lhpf_pkg::RIGHT_START_RESET;
         cfg_ff.center_ref  <= lhpf_pkg::CENTER_REF_RESET;
      end else if (csr_write_enable) begin
         unique case (lhpf_pkg::csr_index_type'(csr_index))
            lhpf_pkg::CSR_FRAME_WIDTH: begin
               cfg_ff.frame_width <= csr_write_data[lhpf_pkg::FWID_W-1:0];
            end
            lhpf_pkg::CSR_ROI_TOP: begin
               cfg_ff.roi_top <= csr_write_data[lhpf_pkg::ROW_W-1:0];
            end
            lhpf_pkg::CSR_ROI_HEIGHT: begin
               cfg_ff.roi_height <= csr_write_data[lhpf_pkg::RHGT_W-1:0];
            end
            lhpf_pkg::CSR_LEFT_END: begin
               cfg_ff.left_end <= csr_write_data[lhpf_pkg::LEND_W-1:0];
            end
            lhpf_pkg::CSR_RIGHT_START: begin
               cfg_ff.right_start <= csr_write_data[lhpf_pkg::COL_W-1:0];
            end
            lhpf_pkg::CSR_CENTER_REF: begin
               cfg_ff.center_ref <= csr_write_data[lhpf_pkg::COL_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Front: classify each request; out-of-band pixels are taken and dropped.
   // ---------------------------------------------------------------------
   assign req_full = cmd_full;

   lhpf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .req_push     (req_push),
      .cmd_full     (cmd_full),
      .req_pixel_on (req_pixel_on),
      .req_column   (req_column),
      .req_row      (req_row),
      .cfg          (cfg_ff),
      .cmd_push     (cmd_push),
      .cmd          (cmd_in_data)
   );

   // Command queue decouples request intake from the count pipeline
   lhpf_queue #(
      .WIDTH (CmdW),
      .DEPTH (lhpf_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty),
      .count     ()
   );

   // ---------------------------------------------------------------------
   // Back: count memory update, peak search, result math.
   // ---------------------------------------------------------------------
   lhpf_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in_data)
   );

   // Response queue; the back end only pushes when room is reserved
   lhpf_queue #(
      .WIDTH (RspW),
      .DEPTH (lhpf_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out_data),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   assign rsp_left_position  = rsp_out_data.left_position;
   assign rsp_right_position = rsp_out_data.right_position;
   assign rsp_lane_center    = rsp_out_data.lane_center;
   assign rsp_center_error   = signed'(rsp_out_data.center_error);

`ifndef SYNTHESIS
   // Back end never pushes a result into a full response queue
   assert property (@(posedge clock) disable iff (reset) rsp_push |-> !rsp_full)
      else $error("result pushed into full response queue");

   // Back end only pops commands that are present
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> !cmd_empty)
      else $error("command popped from empty queue");

   // A classified pixel is visible to the back end on the next cycle
   assert property (@(posedge clock) disable iff (reset) cmd_push |=> !cmd_empty)
      else $error("pushed command lost");
`endif

endmodule

`default_nettype wire
